### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the rtl files; spf_core includes them
// the including module must have signals named clk and rst in scope
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock, quiet while in reset
`define SPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the clock after the antecedent
`define SPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  `SPF_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### hw/rtl/spf_pkg.sv
// ---------------------------------------------------------------------------
// spf_pkg
// types, constants and the half-step table of the stepper position follower
// ---------------------------------------------------------------------------
package spf_pkg;

  // highest position level a target may take
  localparam logic [3:0] MAX_LEVEL   = 4'd15;
  // position and targets after reset
  localparam logic [3:0] RESET_LEVEL = 4'd15;
  // half-steps per unit after reset
  localparam logic [7:0] RESET_HSPU  = 8'd48;

  // item kinds
  typedef enum logic {
    KIND_SET_TARGET = 1'b0,
    KIND_TICK       = 1'b1
  } kind_t;

  // one input item
  typedef struct packed {
    kind_t      kind;
    logic [3:0] target_level;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [3:0] coil_pattern;
    logic       stepped;
    logic       moving;
    logic [3:0] position;
  } out_item_t;

  // half-step coil patterns, bit0 = first coil
  function automatic logic [3:0] half_step_pattern(input logic [2:0] idx);
    logic [3:0] pat;
    unique case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

### hw/rtl/spf_in_reg.sv
// ---------------------------------------------------------------------------
// spf_in_reg
// input register: holds one accepted item until the step logic takes it
// ---------------------------------------------------------------------------
module spf_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_valid,
  output logic              s_ready,
  input  spf_pkg::in_item_t s_item,
  output logic              q_valid,
  input  logic              q_take,
  output spf_pkg::in_item_t q_item
);
  import spf_pkg::*;

  logic     valid;
  in_item_t item;

  // free when empty or when the held item leaves this cycle
  assign s_ready = !valid || q_take;
  assign q_valid = valid;
  assign q_item  = item;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item <= s_item;
    end
  end

endmodule

### hw/rtl/spf_core.sv
// ---------------------------------------------------------------------------
// spf_core
// move state and half-step logic, one item per cycle while proc is high
// ---------------------------------------------------------------------------
module spf_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               proc,
  input  spf_pkg::in_item_t  item,
  output spf_pkg::out_item_t result
);
  import spf_pkg::*;

  `include "assert_macros.svh"

  logic [7:0]  hspu;
  logic [3:0]  position_level, position_level_next;
  logic [3:0]  target_reg;
  logic [3:0]  move_target, move_target_next;
  logic [11:0] steps_left, steps_left_next;
  logic [2:0]  phase_count, phase_count_next;
  logic        going_down, going_down_next;
  logic [3:0]  coil_reg, coil_reg_next;

  logic        is_tick;
  logic        start;
  logic        down_now;
  logic [3:0]  diff;
  logic [11:0] prod;
  logic [11:0] steps_a;
  logic [2:0]  phase_a;
  logic        step_now;
  logic [2:0]  idx;
  logic [3:0]  lvl_sat;

  // next state for one item
  always_comb begin
    is_tick  = (item.kind == KIND_TICK);
    start    = is_tick && (steps_left == 12'd0) && (position_level != target_reg);
    down_now = position_level > target_reg;
    diff     = down_now ? (position_level - target_reg) : (target_reg - position_level);
    prod     = {4'd0, hspu} * {8'd0, diff};

    // move start
    steps_a          = start ? prod : steps_left;
    phase_a          = start ? 3'd0 : phase_count;
    move_target_next = start ? target_reg : move_target;
    going_down_next  = start ? down_now : going_down;

    // half-step
    step_now         = is_tick && (steps_a != 12'd0);
    idx              = going_down_next ? (3'd7 - phase_a) : phase_a;
    coil_reg_next    = step_now ? half_step_pattern(idx) : coil_reg;
    phase_count_next = step_now ? (phase_a + 3'd1) : phase_a;
    steps_left_next  = step_now ? (steps_a - 12'd1) : steps_a;

    // position settles when the move has no half-steps left
    if ((start || step_now) && (steps_left_next == 12'd0)) begin
      position_level_next = move_target_next;
    end else begin
      position_level_next = position_level;
    end

    lvl_sat = (item.target_level > MAX_LEVEL) ? MAX_LEVEL : item.target_level;

    result.coil_pattern = coil_reg_next;
    result.stepped      = step_now;
    result.moving       = (steps_left_next != 12'd0);
    result.position     = position_level_next;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      hspu <= RESET_HSPU;
    end else if (cfg_we) begin
      hspu <= cfg_wdata;
    end
  end

  // move state
  always_ff @(posedge clk) begin
    if (rst) begin
      position_level <= RESET_LEVEL;
      target_reg     <= RESET_LEVEL;
      move_target    <= RESET_LEVEL;
      steps_left     <= 12'd0;
      phase_count    <= 3'd0;
      going_down     <= 1'b0;
      coil_reg       <= 4'd0;
    end else if (proc) begin
      if (is_tick) begin
        position_level <= position_level_next;
        move_target    <= move_target_next;
        steps_left     <= steps_left_next;
        phase_count    <= phase_count_next;
        going_down     <= going_down_next;
        coil_reg       <= coil_reg_next;
      end else begin
        target_reg <= lvl_sat;
      end
    end
  end

  // position only moves on a processed tick
  `SPF_ASSERT_NEXT(a_pos_tick_only, !(proc && is_tick), $stable(position_level),
                   "position changed without a tick")
  // a running move loses exactly one half-step per tick
  `SPF_ASSERT_NEXT(a_step_count, proc && is_tick && (steps_left != 12'd0),
                   steps_left == $past(steps_left) - 12'd1,
                   "half-step count did not decrement")
  // an issued half-step drives one coil or two neighbors
  `SPF_ASSERT_NEXT(a_coil_shape, proc && step_now,
                   ($countones(coil_reg) == 1) || ($countones(coil_reg) == 2),
                   "bad coil pattern after half-step")

endmodule

### hw/rtl/spf_out_reg.sv
// ---------------------------------------------------------------------------
// spf_out_reg
// result register: holds one result until the downstream side takes it
// ---------------------------------------------------------------------------
module spf_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               d_valid,
  output logic               d_ready,
  input  spf_pkg::out_item_t d_item,
  output logic               m_valid,
  input  logic               m_ready,
  output spf_pkg::out_item_t m_item
);
  import spf_pkg::*;

  logic      valid;
  out_item_t item;

  // a new result may load when empty or when the held one is taken
  assign d_ready = !valid || m_ready;
  assign m_valid = valid;
  assign m_item  = item;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (d_ready) begin
      valid <= d_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (d_ready && d_valid) begin
      item <= d_item;
    end
  end

endmodule

### hw/rtl/stepper_position_follower_top.sv
// ---------------------------------------------------------------------------
// stepper_position_follower_top
// half-step sequencer making a four-coil stepper follow a target level
// ---------------------------------------------------------------------------
//  channel  | direction | content
//  s_axis   | in        | tuser: kind (0 set target, 1 tick); tdata: target_level
//  m_axis   | out       | tdata: coil_pattern, stepped, moving, position
//  cfg      | in        | cfg_wdata: half_steps_per_unit, written when cfg_we
//
//  one item per cycle unless m_axis stalls; a taken item passes the input register,
//  then the step logic into the result register, whose output is m_axis
//  reset (rst, synchronous) sets position and targets to 15, coils off, 48 per unit
//  a stalled m_axis fills the result and input registers, then drops s_axis_tready
// ---------------------------------------------------------------------------
module stepper_position_follower_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] target_level, [7:4] zero
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [3:0] coil_pattern, [4] stepped,
                                      // [5] moving, [9:6] position, [15:10] zero
);
  import spf_pkg::*;

  in_item_t  s_item;
  in_item_t  q_item;
  logic      q_valid;
  logic      d_ready;
  logic      proc;
  out_item_t core_result;
  out_item_t m_item;

  // unpack the input item
  always_comb begin
    s_item.kind         = kind_t'(s_axis_tuser);
    s_item.target_level = s_axis_tdata[3:0];
  end

  assign proc = q_valid && d_ready;

  spf_in_reg u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_item  (s_item),
    .q_valid (q_valid),
    .q_take  (d_ready),
    .q_item  (q_item)
  );

  spf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .proc      (proc),
    .item      (q_item),
    .result    (core_result)
  );

  spf_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .d_valid (q_valid),
    .d_ready (d_ready),
    .d_item  (core_result),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_item  (m_item)
  );

  // pack the result item
  assign m_axis_tdata = {6'd0, m_item.position, m_item.moving, m_item.stepped,
                         m_item.coil_pattern};

endmodule
